[sv/lifr_pkg.sv]
// ----------------------------------------------------------------------------
// lifr_pkg: shared types and constants of the linear interpolation resampler
// Item layouts, register indexes and reset values, controller states, and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lifr_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int SPAN_W       = 16;
    // Interpolation numerator magnitude is at most span * 2^(SAMPLE_WIDTH-1).
    localparam int DIV_W        = SAMPLE_WIDTH + SPAN_W - 1;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 16;

    localparam int RATE_IN  = 44100;
    localparam int RATE_OUT = 16000;

    localparam logic [SPAN_W-1:0] SPAN_RESET       = SPAN_W'(RATE_OUT - 1);
    localparam logic [SPAN_W-1:0] STEP_WHOLE_RESET = SPAN_W'((RATE_IN - 1) / (RATE_OUT - 1));
    localparam logic [SPAN_W-1:0] STEP_PART_RESET  = SPAN_W'((RATE_IN - 1) % (RATE_OUT - 1));

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_OUT_SPAN   = 2'd0,
        CFG_STEP_WHOLE = 2'd1,
        CFG_STEP_PART  = 2'd2,
        CFG_BYPASS     = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_in;
        logic                           frame_end;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_out;
        logic                           out_last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NORM,
        ST_NORM_WAIT,
        ST_STEP,
        ST_STEP_WAIT,
        ST_LOOP,
        ST_MUL_A,
        ST_MUL_B,
        ST_SUM,
        ST_INT_DIV,
        ST_INT_WAIT,
        ST_INT_EMIT,
        ST_EXACT_EMIT,
        ST_FINISH,
        ST_BYPASS
    } state_t;

    typedef enum logic [1:0] {
        EMIT_INTERP,
        EMIT_EXACT,
        EMIT_FINAL,
        EMIT_BYPASS
    } emit_src_t;

    typedef struct packed {
        logic      accept;
        logic      norm_start;
        logic      norm_load;
        logic      step_direct;
        logic      step_start;
        logic      step_load;
        logic      advance;
        logic      mul_a;
        logic      mul_b;
        logic      sum;
        logic      int_start;
        logic      emit;
        emit_src_t emit_src;
        logic      finish;
        logic      bypass_finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic bypass;
        logic fend;
        logic rem_ge_span;
        logic step_ge_span;
        logic div_busy;
        logic div_done;
        logic cnt_lt_span;
        logic hit_interp;
        logic hit_exact;
        logic can_emit;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

[sv/lifr_div.sv]
// ----------------------------------------------------------------------------
// lifr_div: serial restoring divider
// Unsigned division of a DIV_W-bit dividend by a non-zero 16-bit divisor, one
// quotient bit per cycle. done pulses for one cycle; results then hold.
// ----------------------------------------------------------------------------
`default_nettype none

module lifr_div #(
    parameter int DIV_W = 31
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [DIV_W-1:0]                dividend,
    input  wire logic [lifr_pkg::SPAN_W-1:0]     divisor,
    output logic                                 busy,
    output logic                                 done,
    output logic [DIV_W-1:0]                     quotient,
    output logic [lifr_pkg::SPAN_W-1:0]          remainder
);

    localparam int CNT_W = $clog2(DIV_W + 1);
    localparam int SW    = lifr_pkg::SPAN_W;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [SW-1:0]     rem_reg, rem_next;
    logic [SW-1:0]     dvs_reg, dvs_next;
    logic [SW:0]       trial;
    logic [SW:0]       diff;
    logic              fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = (trial >= {1'b0, dvs_reg});

        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = busy_reg && (cnt_reg == CNT_W'(1));
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
            // The partial remainder always stays below the divisor.
            rem_next = fits ? diff[SW-1:0] : trial[SW-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

[sv/lifr_dpath.sv]
// ----------------------------------------------------------------------------
// lifr_dpath: resampler datapath
// Configuration registers, frame position state, the shared multiplier, the
// serial divider and output register, driven by cfg writes and controller commands.
// ----------------------------------------------------------------------------
`default_nettype none

module lifr_dpath #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [lifr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [lifr_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire lifr_pkg::in_item_t                   in_item,
    input  wire logic                                 out_ready,
    output logic                                      out_valid,
    output lifr_pkg::out_item_t                       out_item,
    input  wire lifr_pkg::ctrl_cmd_t                  cmd,
    output lifr_pkg::dp_status_t                      status
);

    localparam int SW     = lifr_pkg::SAMPLE_WIDTH;
    localparam int SPW    = lifr_pkg::SPAN_W;
    localparam int DIV_W  = lifr_pkg::DIV_W;
    localparam int POS_W  = COUNT_WIDTH + 1;
    localparam int WIDE_W = ((POS_W > SPW) ? POS_W : SPW) + 2;
    localparam int PROD_W = SW + SPW + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam logic [WIDE_W-1:0] WHOLE_MAX = {{(WIDE_W - POS_W){1'b0}}, {POS_W{1'b1}}};

    // Configuration registers.
    logic [SPW-1:0] span_cfg_reg, span_cfg_next;
    logic [SPW-1:0] step_whole_cfg_reg, step_whole_cfg_next;
    logic [SPW-1:0] step_part_cfg_reg, step_part_cfg_next;
    logic           bypass_cfg_reg, bypass_cfg_next;

    // Frame state.
    logic signed [SW-1:0]   prev_reg, prev_next;
    logic [COUNT_WIDTH-1:0] in_index_reg, in_index_next;
    logic [POS_W-1:0]       next_whole_reg, next_whole_next;
    logic [SPW-1:0]         next_rem_reg, next_rem_next;
    logic [POS_W-1:0]       out_count_reg, out_count_next;

    // Per-item working registers.
    logic signed [SW-1:0]   cur_reg, cur_next;
    logic                   fend_reg, fend_next;
    logic [1:0]             emit_cnt_reg, emit_cnt_next;
    logic [SPW:0]           step_w_reg, step_w_next;
    logic [SPW-1:0]         step_p_reg, step_p_next;
    logic signed [PROD_W-1:0] prod_a_reg, prod_a_next;
    logic signed [PROD_W-1:0] prod_b_reg, prod_b_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;

    logic                   out_valid_reg, out_valid_next;
    lifr_pkg::out_item_t    out_item_reg, out_item_next;

    logic [SPW-1:0]         span;
    logic [SPW-1:0]         span_minus_rem;
    logic signed [SPW:0]    mul_a;
    logic signed [SW-1:0]   mul_b;
    logic signed [PROD_W-1:0] product;
    logic [SUM_W-1:0]       mag_full;
    logic [DIV_W-1:0]       div_dividend;
    logic                   div_start;
    logic                   div_busy;
    logic                   div_done;
    logic [DIV_W-1:0]       div_quo;
    logic [SPW-1:0]         div_rem;
    logic [SW-1:0]          q_low;
    logic [SW-1:0]          int_val;
    logic [SPW:0]           rem_sum;
    logic [SPW:0]           rem_diff;
    logic                   rem_carry;
    logic [WIDE_W-1:0]      whole_adv_sum;
    logic [WIDE_W-1:0]      whole_norm_sum;
    logic                   out_free;

    // A span of zero behaves as one.
    assign span           = (span_cfg_reg == '0) ? SPW'(1) : span_cfg_reg;
    assign span_minus_rem = span - next_rem_reg;

    // One multiplier serves both products of the interpolation.
    assign mul_a   = cmd.mul_b ? $signed({1'b0, next_rem_reg}) : $signed({1'b0, span_minus_rem});
    assign mul_b   = cmd.mul_b ? cur_reg : prev_reg;
    assign product = mul_a * mul_b;

    assign mag_full = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;

    always_comb
    begin
        div_dividend = mag_full[DIV_W-1:0];
        if (cmd.norm_start)
        begin
            div_dividend = DIV_W'(next_rem_reg);
        end
        else if (cmd.step_start)
        begin
            div_dividend = DIV_W'(step_part_cfg_reg);
        end
    end

    assign div_start = cmd.norm_start | cmd.step_start | cmd.int_start;

    lifr_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (span),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // The quotient magnitude never exceeds 2^(SW-1), so its sign is restored here.
    assign q_low   = div_quo[SW-1:0];
    assign int_val = sum_reg[SUM_W-1] ? (~q_low + 1'b1) : q_low;

    // Position step: the step remainder is below the span, so one subtract suffices.
    assign rem_sum       = {1'b0, next_rem_reg} + {1'b0, step_p_reg};
    assign rem_diff      = rem_sum - {1'b0, span};
    assign rem_carry     = (rem_sum >= {1'b0, span});
    assign whole_adv_sum = WIDE_W'(next_whole_reg) + WIDE_W'(step_w_reg) + WIDE_W'(rem_carry);
    assign whole_norm_sum = WIDE_W'(next_whole_reg) + WIDE_W'(div_quo[SPW-1:0]);

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        span_cfg_next       = span_cfg_reg;
        step_whole_cfg_next = step_whole_cfg_reg;
        step_part_cfg_next  = step_part_cfg_reg;
        bypass_cfg_next     = bypass_cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                lifr_pkg::CFG_OUT_SPAN:   span_cfg_next       = cfg_data[SPW-1:0];
                lifr_pkg::CFG_STEP_WHOLE: step_whole_cfg_next = cfg_data[SPW-1:0];
                lifr_pkg::CFG_STEP_PART:  step_part_cfg_next  = cfg_data[SPW-1:0];
                lifr_pkg::CFG_BYPASS:     bypass_cfg_next     = cfg_data[0];
                default:                  bypass_cfg_next     = bypass_cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        prev_next       = prev_reg;
        in_index_next   = in_index_reg;
        next_whole_next = next_whole_reg;
        next_rem_next   = next_rem_reg;
        out_count_next  = out_count_reg;
        cur_next        = cur_reg;
        fend_next       = fend_reg;
        emit_cnt_next   = emit_cnt_reg;
        step_w_next     = step_w_reg;
        step_p_next     = step_p_reg;
        prod_a_next     = prod_a_reg;
        prod_b_next     = prod_b_reg;
        sum_next        = sum_reg;
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;

        if (cmd.accept)
        begin
            cur_next      = in_item.sample_in;
            fend_next     = in_item.frame_end;
            emit_cnt_next = '0;
        end

        if (cmd.norm_load)
        begin
            next_whole_next = (whole_norm_sum > WHOLE_MAX) ? '1 : whole_norm_sum[POS_W-1:0];
            next_rem_next   = div_rem;
        end

        if (cmd.step_direct)
        begin
            step_w_next = {1'b0, step_whole_cfg_reg};
            step_p_next = step_part_cfg_reg;
        end

        if (cmd.step_load)
        begin
            step_w_next = {1'b0, step_whole_cfg_reg} + {1'b0, div_quo[SPW-1:0]};
            step_p_next = div_rem;
        end

        if (cmd.mul_a)
        begin
            prod_a_next = product;
        end

        if (cmd.mul_b)
        begin
            prod_b_next = product;
        end

        if (cmd.sum)
        begin
            sum_next = {prod_a_reg[PROD_W-1], prod_a_reg} + {prod_b_reg[PROD_W-1], prod_b_reg};
        end

        if (cmd.advance)
        begin
            next_whole_next = (whole_adv_sum > WHOLE_MAX) ? '1 : whole_adv_sum[POS_W-1:0];
            next_rem_next   = rem_carry ? rem_diff[SPW-1:0] : rem_sum[SPW-1:0];
            if (out_count_reg != '1)
            begin
                out_count_next = out_count_reg + 1'b1;
            end
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            case (cmd.emit_src)
                lifr_pkg::EMIT_INTERP:
                begin
                    out_item_next.sample_out = int_val;
                    out_item_next.out_last   = 1'b0;
                end
                lifr_pkg::EMIT_EXACT:
                begin
                    out_item_next.sample_out = cur_reg;
                    out_item_next.out_last   = 1'b0;
                end
                lifr_pkg::EMIT_FINAL:
                begin
                    out_item_next.sample_out = cur_reg;
                    out_item_next.out_last   = 1'b1;
                end
                default:
                begin
                    out_item_next.sample_out = cur_reg;
                    out_item_next.out_last   = fend_reg;
                end
            endcase
            if ((cmd.emit_src == lifr_pkg::EMIT_INTERP) || (cmd.emit_src == lifr_pkg::EMIT_EXACT))
            begin
                emit_cnt_next = emit_cnt_reg + 1'b1;
            end
        end

        if (cmd.finish || cmd.bypass_finish)
        begin
            prev_next = cur_reg;
            if (fend_reg)
            begin
                in_index_next   = '0;
                next_whole_next = '0;
                next_rem_next   = '0;
                out_count_next  = '0;
            end
            else if (cmd.finish && (in_index_reg != '1))
            begin
                in_index_next = in_index_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_cfg_reg       <= lifr_pkg::SPAN_RESET;
            step_whole_cfg_reg <= lifr_pkg::STEP_WHOLE_RESET;
            step_part_cfg_reg  <= lifr_pkg::STEP_PART_RESET;
            bypass_cfg_reg     <= 1'b0;
            prev_reg           <= '0;
            in_index_reg       <= '0;
            next_whole_reg     <= '0;
            next_rem_reg       <= '0;
            out_count_reg      <= '0;
            emit_cnt_reg       <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            span_cfg_reg       <= span_cfg_next;
            step_whole_cfg_reg <= step_whole_cfg_next;
            step_part_cfg_reg  <= step_part_cfg_next;
            bypass_cfg_reg     <= bypass_cfg_next;
            prev_reg           <= prev_next;
            in_index_reg       <= in_index_next;
            next_whole_reg     <= next_whole_next;
            next_rem_reg       <= next_rem_next;
            out_count_reg      <= out_count_next;
            emit_cnt_reg       <= emit_cnt_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        fend_reg     <= fend_next;
        step_w_reg   <= step_w_next;
        step_p_reg   <= step_p_next;
        prod_a_reg   <= prod_a_next;
        prod_b_reg   <= prod_b_next;
        sum_reg      <= sum_next;
        out_item_reg <= out_item_next;
    end

    always_comb
    begin
        status.bypass       = bypass_cfg_reg;
        status.fend         = fend_reg;
        status.rem_ge_span  = (next_rem_reg >= span);
        status.step_ge_span = (step_part_cfg_reg >= span);
        status.div_busy     = div_busy;
        status.div_done     = div_done;
        status.cnt_lt_span  = (WIDE_W'(out_count_reg) < WIDE_W'(span));
        status.hit_interp   = ((WIDE_W'(next_whole_reg) + WIDE_W'(1)) == WIDE_W'(in_index_reg))
                              && (next_rem_reg != '0);
        status.hit_exact    = (WIDE_W'(next_whole_reg) == WIDE_W'(in_index_reg))
                              && (next_rem_reg == '0) && !fend_reg;
        status.can_emit     = fend_reg ? (emit_cnt_reg == 2'd0) : (emit_cnt_reg != 2'd2);
        status.out_free     = out_free;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

[sv/lifr_ctrl.sv]
// ----------------------------------------------------------------------------
// lifr_ctrl: resampler controller
// Sequences one input item: remainder and step normalisation, the walk over
// output positions, the interpolation products and division, and the outputs, or a bypass.
// ----------------------------------------------------------------------------
`default_nettype none

module lifr_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire lifr_pkg::dp_status_t  status,
    output lifr_pkg::ctrl_cmd_t        cmd,
    output lifr_pkg::state_t           state
);

    lifr_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lifr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.emit_src = lifr_pkg::EMIT_INTERP;
        in_ready     = 1'b0;

        case (state_reg)
            lifr_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = status.bypass ? lifr_pkg::ST_BYPASS : lifr_pkg::ST_NORM;
                end
            end
            lifr_pkg::ST_NORM:
            begin
                // A remainder left at or above a newly written span is folded into the whole part.
                if (status.rem_ge_span)
                begin
                    cmd.norm_start = 1'b1;
                    state_next     = lifr_pkg::ST_NORM_WAIT;
                end
                else
                begin
                    state_next = lifr_pkg::ST_STEP;
                end
            end
            lifr_pkg::ST_NORM_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.norm_load = 1'b1;
                    state_next    = lifr_pkg::ST_STEP;
                end
            end
            lifr_pkg::ST_STEP:
            begin
                if (status.step_ge_span)
                begin
                    cmd.step_start = 1'b1;
                    state_next     = lifr_pkg::ST_STEP_WAIT;
                end
                else
                begin
                    cmd.step_direct = 1'b1;
                    state_next      = lifr_pkg::ST_LOOP;
                end
            end
            lifr_pkg::ST_STEP_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.step_load = 1'b1;
                    state_next    = lifr_pkg::ST_LOOP;
                end
            end
            lifr_pkg::ST_LOOP:
            begin
                // Positions past the per-item limit are stepped over without a value.
                if (status.cnt_lt_span && status.hit_interp)
                begin
                    if (status.can_emit)
                    begin
                        state_next = lifr_pkg::ST_MUL_A;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                    end
                end
                else if (status.cnt_lt_span && status.hit_exact)
                begin
                    if (status.can_emit)
                    begin
                        state_next = lifr_pkg::ST_EXACT_EMIT;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                    end
                end
                else
                begin
                    state_next = lifr_pkg::ST_FINISH;
                end
            end
            lifr_pkg::ST_MUL_A:
            begin
                cmd.mul_a  = 1'b1;
                state_next = lifr_pkg::ST_MUL_B;
            end
            lifr_pkg::ST_MUL_B:
            begin
                cmd.mul_b  = 1'b1;
                state_next = lifr_pkg::ST_SUM;
            end
            lifr_pkg::ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = lifr_pkg::ST_INT_DIV;
            end
            lifr_pkg::ST_INT_DIV:
            begin
                cmd.int_start = 1'b1;
                state_next    = lifr_pkg::ST_INT_WAIT;
            end
            lifr_pkg::ST_INT_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = lifr_pkg::ST_INT_EMIT;
                end
            end
            lifr_pkg::ST_INT_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = lifr_pkg::EMIT_INTERP;
                    cmd.advance  = 1'b1;
                    state_next   = lifr_pkg::ST_LOOP;
                end
            end
            lifr_pkg::ST_EXACT_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = lifr_pkg::EMIT_EXACT;
                    cmd.advance  = 1'b1;
                    state_next   = lifr_pkg::ST_LOOP;
                end
            end
            lifr_pkg::ST_FINISH:
            begin
                if (!status.fend)
                begin
                    cmd.finish = 1'b1;
                    state_next = lifr_pkg::ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = lifr_pkg::EMIT_FINAL;
                    cmd.finish   = 1'b1;
                    state_next   = lifr_pkg::ST_IDLE;
                end
            end
            lifr_pkg::ST_BYPASS:
            begin
                if (status.out_free)
                begin
                    cmd.emit          = 1'b1;
                    cmd.emit_src      = lifr_pkg::EMIT_BYPASS;
                    cmd.bypass_finish = 1'b1;
                    state_next        = lifr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lifr_pkg::ST_IDLE;
            end
        endcase
    end

    assign state = state_reg;

endmodule

`default_nettype wire

[sv/linear_interp_frame_resampler.sv]
// ----------------------------------------------------------------------------
// linear_interp_frame_resampler: linear interpolation frame resampler
// Resamples frames of signed PCM samples to a programmed output count.
// ----------------------------------------------------------------------------
// Usage: input samples of a frame arrive in order on in_valid/in_ready, the
// last one with frame_end set. Results leave on out_valid/out_ready, at most
// two per input item; the final output of a frame equals its last input and
// carries out_last. Registers out_span, step_whole, step_part and bypass are
// written through cfg_we/cfg_index/cfg_data only while no item is in
// progress; the user must keep to this, as the block does not enforce it.
// Timing: one item is in work at a time. For each interpolated result the
// controller tests the position, does the multiply and add, starts the
// bit-serial divider and waits for it, then emits. An output position that
// lands on a sample is emitted directly, and one past the per-item output
// limit is stepped over. The remainder and step fold-ups also use the
// divider and run only after the span has been lowered or when step_part
// is not below it.
// Reset restores the registers to their defaults and clears the frame state.
// A single output register holds a finished result; while the receiver stalls
// it is kept and the controller waits before writing the next result.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_interp_frame_resampler #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire lifr_pkg::in_item_t               in_item,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output lifr_pkg::out_item_t                   out_item,
    input  wire logic                             cfg_we,
    input  wire logic [lifr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [lifr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    lifr_pkg::ctrl_cmd_t  cmd;
    lifr_pkg::dp_status_t status;
    lifr_pkg::state_t     state;

    lifr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd),
        .state    (state)
    );

    lifr_dpath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_item),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_item  (out_item),
        .cmd       (cmd),
        .status    (status)
    );

    // A result is only written when the output register is empty or being taken.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid || out_ready))
        else $error("result written over an untaken output item");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.norm_start || cmd.step_start || cmd.int_start) |-> !status.div_busy)
        else $error("divider started while busy");

    a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> ((state == lifr_pkg::ST_NORM_WAIT) ||
                             (state == lifr_pkg::ST_STEP_WAIT) ||
                             (state == lifr_pkg::ST_INT_WAIT)))
        else $error("divider finished outside a waiting state");

    a_rem_below_span: assert property (@(posedge clk) disable iff (!rst_n)
        (state == lifr_pkg::ST_LOOP) |-> !status.rem_ge_span)
        else $error("position remainder not below span during the output walk");

endmodule

`default_nettype wire
